@@ rtl/fpfc_pkg.sv @@
// Shared types, constants and the count digit function of the field prefix front coder.
`default_nettype none

package fpfc_pkg;

    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
    localparam logic [7:0] SEPARATOR_RESET = 8'd35;
    localparam logic [7:0] FIELD_SAT       = 8'd255;
    localparam logic [5:0] BYTE_SAT        = 6'd63;

    // One result entry: byte plus end-of-run mark
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } out_entry_t;

    // Count 0..35 coded as 0-9 then a-z, larger counts clamp to z
    function automatic logic [7:0] count_digit(input logic [5:0] n);
        logic [7:0] d;
        if (n < 6'd10) begin
            d = 8'h30 + {2'b00, n};
        end else if (n < 6'd36) begin
            d = 8'h57 + {2'b00, n};
        end else begin
            d = 8'h7a;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fpfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data (old data on collision).
`default_nettype none

module fpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/field_prefix_front_coder.sv @@
// Top level of the field prefix front coder: input register, coding logic, result queue.
//
// Input stream (s_*): one transfer carries one text byte in s_tdata, or, with s_tlast
// high, the end-of-input mark (s_tdata ignored). Newline (10) ends a line; the byte in
// the separator register splits a line into fields. Result stream (m_*): emitted bytes
// in m_tdata, m_tlast high on the last byte caused by one input transfer. An input
// transfer gives zero, one or two result transfers.
// The separator register is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle; the block does not enforce it. Throughput: one input
// transfer per cycle while results drain; each input waits its turn for the single read
// of the previous-line byte store and length store, issued at the edge it is taken.
// Items that emit two bytes drain at one byte per cycle through a four-entry result queue,
// which throttles the input when fewer than two entries are free.
// Reset (aresetn low, synchronous) clears the counters, the queue and the separator
// (back to '#'); the stores are not cleared, only entries written by an earlier line
// are ever compared. A stalled m_tready fills the queue and then drops s_tready.
`default_nettype none

module field_prefix_front_coder #(
    parameter int MAX_FIELDS = 16,
    parameter int MAX_CHARS  = 35
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,   // separator
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] in_byte
    input  wire logic       s_tlast,       // end_of_input
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic            m_tlast        // last_of_run
);

    localparam int BYTE_DEPTH = MAX_FIELDS * MAX_CHARS;
    localparam int BYTE_AW    = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
    localparam int LEN_AW     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int SUM_W      = BYTE_AW + 6;
    localparam logic [7:0] MAX_FIELDS_B = 8'(MAX_FIELDS);
    localparam logic [5:0] MAX_CHARS_B  = 6'(MAX_CHARS);
    localparam logic [BYTE_AW-1:0] ROW_STEP = BYTE_AW'(MAX_CHARS);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // Line state
    logic [7:0]         sep_reg, sep_next;
    logic [7:0]         fi_reg, fi_next;
    logic [5:0]         bi_reg, bi_next;
    logic [7:0]         pfc_reg, pfc_next;
    logic               pm_reg, pm_next;
    logic [BYTE_AW-1:0] base_reg, base_next;

    // Result queue
    fpfc_pkg::out_entry_t q_mem [4];
    logic [1:0] q_wp_reg, q_rp_reg;
    logic [2:0] q_cnt_reg;
    logic       q_pop;

    // Store ports
    logic               byte_we, byte_re;
    logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
    logic [7:0]         byte_rdata;
    logic [SUM_W-1:0]   byte_rsum;
    logic               len_we, len_re;
    logic [LEN_AW-1:0]  len_waddr, len_raddr;
    logic [5:0]         len_wdata, len_rdata, len_cur;
    logic               len_fwd_valid_reg;
    logic [5:0]         len_fwd_reg;

    // Step logic
    logic       fire, accept;
    logic       is_eol, is_sep, empty_eoi, in_window, match;
    logic [5:0] digit;
    logic [1:0] n_out;
    logic [7:0] out0, out1;

    assign fire     = in_valid_reg && (q_cnt_reg <= 3'd2);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign is_eol    = in_eoi_reg || (in_byte_reg == fpfc_pkg::NEWLINE_BYTE);
    assign is_sep    = in_byte_reg == sep_reg;
    assign empty_eoi = in_eoi_reg && (fi_reg == 8'd0) && (bi_reg == 6'd0);
    assign in_window = (fi_reg < MAX_FIELDS_B) && (bi_reg < MAX_CHARS_B);
    assign digit     = bi_reg;
    assign len_cur   = len_fwd_valid_reg ? len_fwd_reg : len_rdata;
    assign match     = (fi_reg < pfc_reg) && (bi_reg < len_cur) && (in_byte_reg == byte_rdata);

    assign byte_waddr = BYTE_AW'({{(SUM_W-BYTE_AW){1'b0}}, base_reg} + {{BYTE_AW{1'b0}}, bi_reg});
    assign len_waddr  = fi_reg[LEN_AW-1:0];
    assign len_wdata  = bi_reg;

    // Coding of one item and the next line state
    always_comb begin
        sep_next  = cfg_wr_en ? cfg_wr_data : sep_reg;
        fi_next   = fi_reg;
        bi_next   = bi_reg;
        pfc_next  = pfc_reg;
        pm_next   = pm_reg;
        base_next = base_reg;
        n_out     = 2'd0;
        out0      = 8'd0;
        out1      = 8'd0;
        byte_we   = 1'b0;
        len_we    = 1'b0;
        if (fire && !empty_eoi) begin
            if (is_eol || is_sep) begin
                // close the field, then newline or separator
                len_we = fi_reg < MAX_FIELDS_B;
                if (pm_reg) begin
                    n_out = 2'd2;
                    out0  = fpfc_pkg::count_digit(digit);
                    out1  = is_eol ? fpfc_pkg::NEWLINE_BYTE : sep_reg;
                end else begin
                    n_out = 2'd1;
                    out0  = is_eol ? fpfc_pkg::NEWLINE_BYTE : sep_reg;
                end
                bi_next = 6'd0;
                if (is_eol) begin
                    pfc_next  = (fi_reg < fpfc_pkg::FIELD_SAT) ? fi_reg + 8'd1 : fpfc_pkg::FIELD_SAT;
                    fi_next   = 8'd0;
                    pm_next   = 1'b1;
                    base_next = '0;
                end else begin
                    fi_next = (fi_reg < fpfc_pkg::FIELD_SAT) ? fi_reg + 8'd1 : fpfc_pkg::FIELD_SAT;
                    pm_next = fi_next < pfc_reg;
                    if (fi_reg < MAX_FIELDS_B - 8'd1) begin
                        base_next = base_reg + ROW_STEP;
                    end
                end
            end else begin
                bi_next = (bi_reg < fpfc_pkg::BYTE_SAT) ? bi_reg + 6'd1 : fpfc_pkg::BYTE_SAT;
                if (!in_window) begin
                    // outside the stored window: plain literal
                    pm_next = 1'b0;
                    if (pm_reg) begin
                        n_out = 2'd2;
                        out0  = fpfc_pkg::count_digit(digit);
                        out1  = in_byte_reg;
                    end else begin
                        n_out = 2'd1;
                        out0  = in_byte_reg;
                    end
                end else if (pm_reg && match) begin
                    // still inside the shared prefix: suppressed
                    pm_next = 1'b1;
                end else begin
                    pm_next = 1'b0;
                    byte_we = 1'b1;
                    if (pm_reg) begin
                        n_out = 2'd2;
                        out0  = fpfc_pkg::count_digit(digit);
                        out1  = in_byte_reg;
                    end else begin
                        n_out = 2'd1;
                        out0  = in_byte_reg;
                    end
                end
            end
        end
    end

    // Store reads for the next item use the state it will see
    assign byte_rsum  = {{(SUM_W-BYTE_AW){1'b0}}, base_next} + {{BYTE_AW{1'b0}}, bi_next};
    assign byte_raddr = byte_rsum[BYTE_AW-1:0];
    assign byte_re    = accept && (fi_next < MAX_FIELDS_B) && (bi_next < MAX_CHARS_B);
    assign len_raddr  = fi_next[LEN_AW-1:0];
    assign len_re     = accept && (fi_next < MAX_FIELDS_B);

    assign in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            sep_reg           <= fpfc_pkg::SEPARATOR_RESET;
            fi_reg            <= 8'd0;
            bi_reg            <= 6'd0;
            pfc_reg           <= 8'd0;
            pm_reg            <= 1'b0;
            base_reg          <= '0;
            len_fwd_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            sep_reg      <= sep_next;
            fi_reg       <= fi_next;
            bi_reg       <= bi_next;
            pfc_reg      <= pfc_next;
            pm_reg       <= pm_next;
            base_reg     <= base_next;
            // length written and read at one edge: keep the new value
            if (len_re) begin
                len_fwd_valid_reg <= len_we && (len_waddr == len_raddr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
        if (len_re) begin
            len_fwd_reg <= len_wdata;
        end
    end

    // Result queue: up to two pushes, one pop per cycle
    assign q_pop    = m_tvalid && m_tready;
    assign m_tvalid = q_cnt_reg != 3'd0;
    assign m_tdata  = q_mem[q_rp_reg].data;
    assign m_tlast  = q_mem[q_rp_reg].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wp_reg  <= 2'd0;
            q_rp_reg  <= 2'd0;
            q_cnt_reg <= 3'd0;
        end else begin
            q_wp_reg  <= q_wp_reg + n_out;
            q_rp_reg  <= q_rp_reg + {1'b0, q_pop};
            q_cnt_reg <= q_cnt_reg + {1'b0, n_out} - {2'b00, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (n_out != 2'd0) begin
            q_mem[q_wp_reg] <= '{last: (n_out == 2'd1), data: out0};
        end
        if (n_out == 2'd2) begin
            q_mem[q_wp_reg + 2'd1] <= '{last: 1'b1, data: out1};
        end
    end

    // Previous line stores
    fpfc_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (in_byte_reg),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    fpfc_ram #(
        .WIDTH (6),
        .DEPTH (MAX_FIELDS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

endmodule

`default_nettype wire
